// ===== design/ptt_pkg.sv =====
// Shared widths, types and constants of the pan/tilt PID servo tracker.
// Used by ptt_mac, ptt_div and pan_tilt_pid_servo_tracker; depends on nothing.
package ptt_pkg;

    // Field widths
    localparam int COORD_BITS = 12;
    localparam int AREA_W     = 32;
    localparam int ERR_W      = COORD_BITS + 1;
    localparam int DERR_W     = COORD_BITS + 2;
    localparam int INTEG_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int THR_W      = 12;
    localparam int SDIV_W     = 8;
    localparam int PWM_W      = 10;

    // Stream and configuration port widths
    localparam int S_FIELDS_W = 2 * COORD_BITS + AREA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 + 2 * PWM_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Serial arithmetic widths
    localparam int MAC_A_W   = INTEG_W;
    localparam int MAC_B_W   = GAIN_W;
    localparam int ACC_W     = 42;
    localparam int FRAC_BITS = 16;
    localparam int ANG_W     = ACC_W - FRAC_BITS;
    localparam int MAP_W     = 12;
    localparam int MAP_LIM   = 2 ** (MAP_W - 1);
    localparam int DIV_N_W   = 16;
    localparam int DIV_D_W   = 8;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    typedef logic        [COORD_BITS-1:0] coord_t;
    typedef logic        [AREA_W-1:0]     area_t;
    typedef logic signed [ERR_W-1:0]      err_t;
    typedef logic signed [DERR_W-1:0]     derr_t;
    typedef logic signed [INTEG_W-1:0]    integ_t;
    typedef logic        [GAIN_W-1:0]     gain_t;
    typedef logic        [THR_W-1:0]      thr_t;
    typedef logic        [SDIV_W-1:0]     sdiv_t;
    typedef logic        [PWM_W-1:0]      pwm_t;
    typedef logic signed [PWM_W:0]        pdiff_t;
    typedef logic signed [MAC_A_W-1:0]    mac_a_t;
    typedef logic        [MAC_B_W-1:0]    mac_b_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic signed [ANG_W-1:0]      ang_t;
    typedef logic signed [MAP_W-1:0]      map_t;
    typedef logic signed [MAP_W+3:0]      scaled_t;
    typedef logic        [DIV_N_W-1:0]    div_n_t;
    typedef logic        [DIV_D_W-1:0]    div_d_t;
    typedef logic        [DIV_CNT_W-1:0]  div_cnt_t;
    typedef logic signed [DIV_N_W:0]      qsig_t;
    typedef logic        [M_TDATA_W-1:0]  m_data_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t REG_CENTER_X   = 3'd0;
    localparam cfg_idx_t REG_CENTER_Y   = 3'd1;
    localparam cfg_idx_t REG_MIN_AREA   = 3'd2;
    localparam cfg_idx_t REG_MOVE_THR   = 3'd3;
    localparam cfg_idx_t REG_GAIN_P     = 3'd4;
    localparam cfg_idx_t REG_GAIN_I     = 3'd5;
    localparam cfg_idx_t REG_GAIN_D     = 3'd6;
    localparam cfg_idx_t REG_SMOOTH_DIV = 3'd7;

    // Register reset values
    localparam coord_t CENTER_X_RST   = coord_t'(320);
    localparam coord_t CENTER_Y_RST   = coord_t'(240);
    localparam area_t  MIN_AREA_RST   = area_t'(10000);
    localparam thr_t   MOVE_THR_RST   = thr_t'(50);
    localparam gain_t  GAIN_P_RST     = gain_t'(13107);
    localparam gain_t  GAIN_I_RST     = gain_t'(2621);
    localparam gain_t  GAIN_D_RST     = gain_t'(1311);
    localparam sdiv_t  SMOOTH_DIV_RST = sdiv_t'(10);
    localparam pwm_t   HELD_X_RST     = pwm_t'(150);
    localparam pwm_t   HELD_Y_RST     = pwm_t'(200);

    // Angle to PWM mapping: X = 10*(a-180)/9 + 250, Y = 2*(180-a)/3 + 150
    localparam ang_t   ANGLE_MID = ang_t'(180);
    localparam ang_t   MAP_HI    = ang_t'(MAP_LIM - 1);
    localparam ang_t   MAP_LO    = ang_t'(-MAP_LIM);
    localparam div_d_t X_DIV     = div_d_t'(9);
    localparam div_d_t Y_DIV     = div_d_t'(3);
    localparam qsig_t  X_OFS     = qsig_t'(250);
    localparam qsig_t  Y_OFS     = qsig_t'(150);
    localparam qsig_t  Y_CAP     = qsig_t'(210);
    localparam qsig_t  PWM_MAX   = qsig_t'(2 ** PWM_W - 1);

    // Serial multiply-accumulate command and status
    typedef struct packed {
        logic   start;
        logic   clr;
        mac_a_t a;
        mac_b_t b;
    } mac_cmd_t;

    typedef struct packed {
        logic busy;
        acc_t acc;
    } mac_stat_t;

    // Serial divider command and status
    typedef struct packed {
        logic   start;
        div_n_t dividend;
        div_d_t divisor;
    } div_cmd_t;

    typedef struct packed {
        logic   busy;
        div_n_t quo;
    } div_stat_t;

endpackage

// ===== design/ptt_mac.sv =====
// Bit-serial signed-by-unsigned multiply-accumulate unit, one multiplier bit per cycle.
// Depends on ptt_pkg.
module ptt_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  ptt_pkg::mac_cmd_t cmd,
    output ptt_pkg::mac_stat_t stat
);

    ptt_pkg::acc_t   acc_reg;
    ptt_pkg::acc_t   a_reg;
    ptt_pkg::mac_b_t b_reg;

    // The multiplier shifts out LSB first; the multiplicand shifts up in step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg <= '0;
        end else if (cmd.start) begin
            b_reg <= cmd.b;
            a_reg <= ptt_pkg::acc_t'(cmd.a);
            if (cmd.clr) begin
                acc_reg <= '0;
            end
        end else if (b_reg != '0) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign stat.busy = |b_reg;
    assign stat.acc  = acc_reg;

endmodule

// ===== design/ptt_div.sv =====
// Restoring serial divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on ptt_pkg.
module ptt_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  ptt_pkg::div_cmd_t cmd,
    output ptt_pkg::div_stat_t stat
);

    ptt_pkg::div_n_t   quo_reg;
    ptt_pkg::div_d_t   rem_reg;
    ptt_pkg::div_d_t   dsr_reg;
    ptt_pkg::div_cnt_t cnt_reg;

    logic [ptt_pkg::DIV_D_W:0] shifted;
    logic [ptt_pkg::DIV_D_W:0] trial;
    logic                      fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign shifted = {rem_reg, quo_reg[ptt_pkg::DIV_N_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    // Dividend bits leave at the top of quo_reg while quotient bits enter below.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.start) begin
            quo_reg <= cmd.dividend;
            rem_reg <= '0;
            dsr_reg <= cmd.divisor;
            cnt_reg <= ptt_pkg::div_cnt_t'(ptt_pkg::DIV_N_W);
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? trial[ptt_pkg::DIV_D_W-1:0] : shifted[ptt_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[ptt_pkg::DIV_N_W-2:0], fits};
            cnt_reg <= cnt_reg - ptt_pkg::div_cnt_t'(1);
        end
    end

    assign stat.busy = |cnt_reg;
    assign stat.quo  = quo_reg;

endmodule

// ===== design/pan_tilt_pid_servo_tracker.sv =====
// Pan/tilt PID servo tracker: top level with configuration registers, sequencer and state.
// Depends on ptt_pkg, ptt_mac and ptt_div.
//
// Use: one beat on the s_ channel per camera frame carries the target centroid and blob
// area. Every input beat yields exactly one result beat on the m_ channel with the
// tracked and moved flags and the held pan and tilt PWM values after that frame.
// The cfg_ channel writes one of eight registers per beat; cfg_ready is always high.
// Write it only while no frame is in flight.
// A frame whose area does not exceed min_area goes straight to its result beat.
// A tracked frame runs nine bit-serial multiplies and two 16-bit serial divides, plus
// two more when the servos move, on the shared multiply-accumulate unit and divider.
// One frame is processed at a time: s_tready is high only while the sequencer is idle.
// A finished result waits in the output register, so the next frame may be taken while
// the receiver stalls; the sequencer holds its next result until that register is free.
// Reset (synchronous, aresetn low) loads the register defaults, clears the integrals and
// last errors, and sets the held PWM values to 150 (pan) and 200 (tilt).
module pan_tilt_pid_servo_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, blob_area (from bit 0 up), zero padded
    input  logic [ptt_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tracked, moved, pwm_x, pwm_y (from bit 0 up), zero padded
    output logic [ptt_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef struct packed {
        ptt_pkg::coord_t center_x;
        ptt_pkg::coord_t center_y;
        ptt_pkg::area_t  min_area;
        ptt_pkg::thr_t   move_thr;
        ptt_pkg::gain_t  gain_p;
        ptt_pkg::gain_t  gain_i;
        ptt_pkg::gain_t  gain_d;
        ptt_pkg::sdiv_t  smooth_div;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_MUL, S_MUL_WAIT, S_MAP, S_MAP_WAIT, S_MAP_END,
        S_CMP, S_SMOOTH, S_SMOOTH_WAIT, S_SMOOTH_END, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_P, OP_I, OP_D, OP_SQ_X, OP_SQ_Y, OP_THR
    } op_t;

    cfg_t cfg_reg;

    state_t state_reg;
    op_t    op_reg;
    logic   axis_y_reg;
    logic   tracked_reg;
    logic   moved_reg;
    logic   neg_reg;
    logic   m_tvalid_reg;

    ptt_pkg::err_t    err_x_reg, err_y_reg;
    ptt_pkg::err_t    last_x_reg, last_y_reg;
    ptt_pkg::integ_t  integ_x_reg, integ_y_reg;
    ptt_pkg::pwm_t    held_x_reg, held_y_reg;
    ptt_pkg::pwm_t    new_x_reg, new_y_reg;
    ptt_pkg::m_data_t m_tdata_reg;

    ptt_pkg::mac_cmd_t  mac_cmd;
    ptt_pkg::mac_stat_t mac_stat;
    ptt_pkg::div_cmd_t  div_cmd;
    ptt_pkg::div_stat_t div_stat;

    logic             s_accept;
    ptt_pkg::coord_t  pos_x_in, pos_y_in;
    ptt_pkg::area_t   area_in;
    logic             tracked_in;
    ptt_pkg::err_t    err_in_x, err_in_y;

    ptt_pkg::err_t    err_cur, last_cur;
    ptt_pkg::integ_t  integ_cur;
    ptt_pkg::derr_t   derr;
    ptt_pkg::err_t    abs_x, abs_y;
    ptt_pkg::coord_t  mag_x, mag_y;

    ptt_pkg::ang_t    ang_floor, ang, off, off_sat;
    logic             round_up;
    ptt_pkg::map_t    off_c;
    ptt_pkg::scaled_t off_w, scaled, scaled_abs;
    ptt_pkg::div_n_t  map_mag;

    ptt_pkg::qsig_t   q_sig, map_x_v, map_y_v, hsum;
    ptt_pkg::pwm_t    map_x, map_y;

    ptt_pkg::pwm_t    held_cur, new_cur;
    ptt_pkg::pdiff_t  sm_diff, sm_abs;
    ptt_pkg::div_n_t  sm_mag;
    ptt_pkg::div_d_t  sm_div;

    // Configuration registers: always ready, one register per beat.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x   <= ptt_pkg::CENTER_X_RST;
            cfg_reg.center_y   <= ptt_pkg::CENTER_Y_RST;
            cfg_reg.min_area   <= ptt_pkg::MIN_AREA_RST;
            cfg_reg.move_thr   <= ptt_pkg::MOVE_THR_RST;
            cfg_reg.gain_p     <= ptt_pkg::GAIN_P_RST;
            cfg_reg.gain_i     <= ptt_pkg::GAIN_I_RST;
            cfg_reg.gain_d     <= ptt_pkg::GAIN_D_RST;
            cfg_reg.smooth_div <= ptt_pkg::SMOOTH_DIV_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ptt_pkg::REG_CENTER_X:   cfg_reg.center_x <= cfg_data[ptt_pkg::COORD_BITS-1:0];
                ptt_pkg::REG_CENTER_Y:   cfg_reg.center_y <= cfg_data[ptt_pkg::COORD_BITS-1:0];
                ptt_pkg::REG_MIN_AREA:   cfg_reg.min_area <= cfg_data[ptt_pkg::AREA_W-1:0];
                ptt_pkg::REG_MOVE_THR:   cfg_reg.move_thr <= cfg_data[ptt_pkg::THR_W-1:0];
                ptt_pkg::REG_GAIN_P:     cfg_reg.gain_p   <= cfg_data[ptt_pkg::GAIN_W-1:0];
                ptt_pkg::REG_GAIN_I:     cfg_reg.gain_i   <= cfg_data[ptt_pkg::GAIN_W-1:0];
                ptt_pkg::REG_GAIN_D:     cfg_reg.gain_d   <= cfg_data[ptt_pkg::GAIN_W-1:0];
                ptt_pkg::REG_SMOOTH_DIV: begin
                    cfg_reg.smooth_div <= cfg_data[ptt_pkg::SDIV_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Input beat unpacking, tracking decision and per-axis errors.
    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid & s_tready;
    assign pos_x_in   = s_tdata[ptt_pkg::COORD_BITS-1:0];
    assign pos_y_in   = s_tdata[2*ptt_pkg::COORD_BITS-1:ptt_pkg::COORD_BITS];
    assign area_in    = s_tdata[ptt_pkg::S_FIELDS_W-1:2*ptt_pkg::COORD_BITS];
    assign tracked_in = area_in > cfg_reg.min_area;
    assign err_in_x   = $signed({1'b0, cfg_reg.center_x}) - $signed({1'b0, pos_x_in});
    assign err_in_y   = $signed({1'b0, cfg_reg.center_y}) - $signed({1'b0, pos_y_in});

    // Saturating add of an error into a 24-bit integral.
    function automatic ptt_pkg::integ_t sat_add(ptt_pkg::integ_t acc, ptt_pkg::err_t e);
        logic signed [ptt_pkg::INTEG_W:0] s;
        ptt_pkg::integ_t                  r;
        s = (ptt_pkg::INTEG_W+1)'(acc) + (ptt_pkg::INTEG_W+1)'(e);
        if (s[ptt_pkg::INTEG_W] != s[ptt_pkg::INTEG_W-1]) begin
            r = s[ptt_pkg::INTEG_W] ? {1'b1, {(ptt_pkg::INTEG_W-1){1'b0}}}
                                    : {1'b0, {(ptt_pkg::INTEG_W-1){1'b1}}};
        end else begin
            r = s[ptt_pkg::INTEG_W-1:0];
        end
        return r;
    endfunction

    // Operands of the current axis and error magnitudes for the distance test.
    assign err_cur   = axis_y_reg ? err_y_reg : err_x_reg;
    assign last_cur  = axis_y_reg ? last_y_reg : last_x_reg;
    assign integ_cur = axis_y_reg ? integ_y_reg : integ_x_reg;
    assign derr      = ptt_pkg::derr_t'(err_cur) - ptt_pkg::derr_t'(last_cur);
    assign abs_x     = err_x_reg[ptt_pkg::ERR_W-1] ? -err_x_reg : err_x_reg;
    assign abs_y     = err_y_reg[ptt_pkg::ERR_W-1] ? -err_y_reg : err_y_reg;
    assign mag_x     = abs_x[ptt_pkg::COORD_BITS-1:0];
    assign mag_y     = abs_y[ptt_pkg::COORD_BITS-1:0];

    // Multiply-accumulate operand selection for each step of the sequence.
    always_comb begin
        mac_cmd.start = (state_reg == S_MUL);
        mac_cmd.clr   = (op_reg == OP_P) || (op_reg == OP_SQ_X);
        unique case (op_reg)
            OP_P: begin
                mac_cmd.a = ptt_pkg::mac_a_t'(err_cur);
                mac_cmd.b = cfg_reg.gain_p;
            end
            OP_I: begin
                mac_cmd.a = ptt_pkg::mac_a_t'(integ_cur);
                mac_cmd.b = cfg_reg.gain_i;
            end
            OP_D: begin
                mac_cmd.a = ptt_pkg::mac_a_t'(derr);
                mac_cmd.b = cfg_reg.gain_d;
            end
            OP_SQ_X: begin
                mac_cmd.a = ptt_pkg::mac_a_t'(mag_x);
                mac_cmd.b = ptt_pkg::mac_b_t'(mag_x);
            end
            OP_SQ_Y: begin
                mac_cmd.a = ptt_pkg::mac_a_t'(mag_y);
                mac_cmd.b = ptt_pkg::mac_b_t'(mag_y);
            end
            OP_THR: begin
                mac_cmd.a = -ptt_pkg::mac_a_t'(cfg_reg.move_thr);
                mac_cmd.b = ptt_pkg::mac_b_t'(cfg_reg.move_thr);
            end
            default: begin
                mac_cmd.a = '0;
                mac_cmd.b = '0;
            end
        endcase
    end

    ptt_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .stat    (mac_stat)
    );

    // PID angle truncated toward zero, offset from 180 and clamped to a range
    // beyond which the mapped PWM value saturates anyway.
    assign ang_floor = mac_stat.acc[ptt_pkg::ACC_W-1:ptt_pkg::FRAC_BITS];
    assign round_up  = mac_stat.acc[ptt_pkg::ACC_W-1] & (|mac_stat.acc[ptt_pkg::FRAC_BITS-1:0]);
    assign ang       = ang_floor + ptt_pkg::ang_t'({1'b0, round_up});
    assign off       = axis_y_reg ? (ptt_pkg::ANGLE_MID - ang) : (ang - ptt_pkg::ANGLE_MID);

    always_comb begin
        if (off > ptt_pkg::MAP_HI) begin
            off_sat = ptt_pkg::MAP_HI;
        end else if (off < ptt_pkg::MAP_LO) begin
            off_sat = ptt_pkg::MAP_LO;
        end else begin
            off_sat = off;
        end
    end

    // Scale by 10 (pan) or 2 (tilt) with shifts; the divider sees the magnitude.
    assign off_c      = off_sat[ptt_pkg::MAP_W-1:0];
    assign off_w      = ptt_pkg::scaled_t'(off_c);
    assign scaled     = axis_y_reg ? (off_w <<< 1) : ((off_w <<< 3) + (off_w <<< 1));
    assign scaled_abs = off_c[ptt_pkg::MAP_W-1] ? -scaled : scaled;
    assign map_mag    = ptt_pkg::div_n_t'(scaled_abs);

    // Signed quotient and the two PWM mappings with their limits.
    assign q_sig   = neg_reg ? -ptt_pkg::qsig_t'(div_stat.quo) : ptt_pkg::qsig_t'(div_stat.quo);
    assign map_x_v = q_sig + ptt_pkg::X_OFS;
    assign map_y_v = q_sig + ptt_pkg::Y_OFS;

    always_comb begin
        if (map_x_v[ptt_pkg::DIV_N_W]) begin
            map_x = '0;
        end else if (map_x_v > ptt_pkg::PWM_MAX) begin
            map_x = ptt_pkg::PWM_MAX[ptt_pkg::PWM_W-1:0];
        end else begin
            map_x = map_x_v[ptt_pkg::PWM_W-1:0];
        end
        if (map_y_v > ptt_pkg::Y_CAP) begin
            map_y = ptt_pkg::Y_CAP[ptt_pkg::PWM_W-1:0];
        end else if (map_y_v[ptt_pkg::DIV_N_W]) begin
            map_y = '0;
        end else begin
            map_y = map_y_v[ptt_pkg::PWM_W-1:0];
        end
    end

    // Smoothing step toward the new PWM value; a zero divisor acts as one.
    assign held_cur = axis_y_reg ? held_y_reg : held_x_reg;
    assign new_cur  = axis_y_reg ? new_y_reg : new_x_reg;
    assign sm_diff  = $signed({1'b0, new_cur}) - $signed({1'b0, held_cur});
    assign sm_abs   = sm_diff[ptt_pkg::PWM_W] ? -sm_diff : sm_diff;
    assign sm_mag   = ptt_pkg::div_n_t'(sm_abs);
    assign sm_div   = (cfg_reg.smooth_div == '0) ? ptt_pkg::div_d_t'(1)
                                                 : ptt_pkg::div_d_t'(cfg_reg.smooth_div);
    assign hsum     = ptt_pkg::qsig_t'($signed({1'b0, held_cur})) + q_sig;

    // Divider shared by the angle mapping and the smoothing step.
    always_comb begin
        div_cmd.start = (state_reg == S_MAP) || (state_reg == S_SMOOTH);
        if (state_reg == S_SMOOTH) begin
            div_cmd.dividend = sm_mag;
            div_cmd.divisor  = sm_div;
        end else begin
            div_cmd.dividend = map_mag;
            div_cmd.divisor  = axis_y_reg ? ptt_pkg::Y_DIV : ptt_pkg::X_DIV;
        end
    end

    ptt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .stat    (div_stat)
    );

    // Sequencer, tracker state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_P;
            axis_y_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            integ_x_reg  <= '0;
            integ_y_reg  <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            held_x_reg   <= ptt_pkg::HELD_X_RST;
            held_y_reg   <= ptt_pkg::HELD_Y_RST;
        end else begin
            // Output valid: set when a result is loaded, cleared when the beat is taken.
            if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        err_x_reg   <= err_in_x;
                        err_y_reg   <= err_in_y;
                        tracked_reg <= tracked_in;
                        moved_reg   <= 1'b0;
                        state_reg   <= tracked_in ? S_ERR : S_DONE;
                    end
                end
                S_ERR: begin
                    integ_x_reg <= sat_add(integ_x_reg, err_x_reg);
                    integ_y_reg <= sat_add(integ_y_reg, err_y_reg);
                    axis_y_reg  <= 1'b0;
                    op_reg      <= OP_P;
                    state_reg   <= S_MUL;
                end
                S_MUL: begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (!mac_stat.busy) begin
                        unique case (op_reg)
                            OP_P: begin
                                op_reg    <= OP_I;
                                state_reg <= S_MUL;
                            end
                            OP_I: begin
                                op_reg    <= OP_D;
                                state_reg <= S_MUL;
                            end
                            OP_D: begin
                                state_reg <= S_MAP;
                            end
                            OP_SQ_X: begin
                                op_reg    <= OP_SQ_Y;
                                state_reg <= S_MUL;
                            end
                            OP_SQ_Y: begin
                                op_reg    <= OP_THR;
                                state_reg <= S_MUL;
                            end
                            default: begin
                                state_reg <= S_CMP;
                            end
                        endcase
                    end
                end
                S_MAP: begin
                    neg_reg   <= off_c[ptt_pkg::MAP_W-1];
                    state_reg <= S_MAP_WAIT;
                end
                S_MAP_WAIT: begin
                    if (!div_stat.busy) begin
                        state_reg <= S_MAP_END;
                    end
                end
                S_MAP_END: begin
                    if (axis_y_reg) begin
                        new_y_reg <= map_y;
                        op_reg    <= OP_SQ_X;
                    end else begin
                        new_x_reg  <= map_x;
                        axis_y_reg <= 1'b1;
                        op_reg     <= OP_P;
                    end
                    state_reg <= S_MUL;
                end
                S_CMP: begin
                    // The accumulator holds ex^2 + ey^2 - threshold^2.
                    if (!mac_stat.acc[ptt_pkg::ACC_W-1]) begin
                        axis_y_reg <= 1'b0;
                        state_reg  <= S_SMOOTH;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_SMOOTH: begin
                    neg_reg   <= sm_diff[ptt_pkg::PWM_W];
                    state_reg <= S_SMOOTH_WAIT;
                end
                S_SMOOTH_WAIT: begin
                    if (!div_stat.busy) begin
                        state_reg <= S_SMOOTH_END;
                    end
                end
                S_SMOOTH_END: begin
                    if (axis_y_reg) begin
                        held_y_reg <= hsum[ptt_pkg::PWM_W-1:0];
                        last_x_reg <= err_x_reg;
                        last_y_reg <= err_y_reg;
                        moved_reg  <= 1'b1;
                        state_reg  <= S_DONE;
                    end else begin
                        held_x_reg <= hsum[ptt_pkg::PWM_W-1:0];
                        axis_y_reg <= 1'b1;
                        state_reg  <= S_SMOOTH;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg <= ptt_pkg::m_data_t'({held_y_reg, held_x_reg,
                                                           moved_reg, tracked_reg});
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
